/* src/tns_pkg.sv */
// Package for the thresholded top-N selector.
// Holds sizes, the kept-entry type, the cell command struct and the control state type.
// No dependencies.
package tns_pkg;

	localparam int MAX_KEEP    = 16;
	localparam int MAX_CLASSES = 4096;

	localparam int SCORE_W = 8;
	localparam int INDEX_W = 12;
	localparam int KEEP_W  = 5;
	localparam int POS_W   = $clog2(MAX_CLASSES) + 1;
	localparam int CNT_W   = $clog2(MAX_KEEP + 1);

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(5);
	localparam logic [POS_W-1:0]  POS_LIMIT  = POS_W'(MAX_CLASSES);

	// configuration register indexes
	localparam logic REG_KEEP_COUNT = 1'b0;
	localparam logic REG_MIN_SCORE  = 1'b1;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [INDEX_W-1:0] index;
		logic               valid;
	} entry_t;

	localparam entry_t EMPTY_ENTRY = '{score: '0, index: '0, valid: 1'b0};

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic               ins;     // insert the new score this cycle
		logic               shift;   // drain: move entries one cell toward the head
		logic               clear;   // end of run: invalidate all cells
		logic [KEEP_W-1:0]  keep;    // effective keep count, 1..MAX_KEEP
		logic [SCORE_W-1:0] score;
		logic [INDEX_W-1:0] index;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_COLLECT = 2'b01,
		ST_DRAIN   = 2'b10
	} state_t;

endpackage

/* src/thresholded_top_n_select.sv */
// Top level of the thresholded top-N selector: controller plus a chain of sorted cells.
// Depends on tns_pkg, tns_ctrl and tns_cell.
//
// Usage:
//  - s_* channel: one score request per cycle while collecting; tdata[7:0] = score,
//    tlast marks the final score of the vector. Scores are numbered from 0 by arrival.
//  - m_* channel: after the closing request, the kept entries come out best first,
//    one per accepted cycle; tlast marks the final one. If nothing reached the
//    minimum, one request with tuser = 0 and zero data is sent.
//  - cfg port: write keep_count (index 0) or min_score (index 1) between runs.
//  - Throughput: one score per cycle while collecting; each of the first 4096 scores
//    at or above the minimum goes into the 16-cell chain in the cycle it is accepted.
//  - Drain: the first result is valid the cycle after the closing score; s_tready is
//    low while the results drain.
//  - m_tready low holds the head result in place; the chain only shifts on accept.
//  - Reset clears the chain, the position counter and the registers to keep_count 5,
//    min_score 0.
module thresholded_top_n_select
	import tns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] score
	input  logic        s_tlast,   // last_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_score, [19:8] class_index, [23:20] zero
	output logic        m_tuser,   // entry_valid
	output logic        m_tlast    // last_out
);

	cell_cmd_t cmd;
	entry_t    cells   [MAX_KEEP];
	logic      disp    [MAX_KEEP];
	entry_t    head;
	logic      second_valid;

	assign head         = cells[0];
	assign second_valid = (MAX_KEEP > 1) ? cells[(MAX_KEEP > 1) ? 1 : 0].valid : 1'b0;

	tns_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_score     (s_tdata[SCORE_W-1:0]),
		.in_last      (s_tlast),
		.in_ready     (s_tready),
		.out_valid    (m_tvalid),
		.out_last     (m_tlast),
		.out_ready    (m_tready),
		.head_valid   (head.valid),
		.second_valid (second_valid),
		.cmd          (cmd)
	);

	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_d;

		if (i == 0) begin : g_head
			assign prev_e = EMPTY_ENTRY;
			assign prev_d = 1'b0;
		end else begin : g_body
			assign prev_e = cells[i-1];
			assign prev_d = disp[i-1];
		end

		if (i == MAX_KEEP - 1) begin : g_tail
			assign next_e = EMPTY_ENTRY;
		end else begin : g_mid
			assign next_e = cells[i+1];
		end

		tns_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.cmd            (cmd),
			.cell_pos       (CNT_W'(i)),
			.prev_entry     (prev_e),
			.prev_displaced (prev_d),
			.next_entry     (next_e),
			.entry          (cells[i]),
			.displaced      (disp[i])
		);
	end

	assign m_tuser = head.valid;
	assign m_tdata = {4'b0000,
		head.valid ? head.index : INDEX_W'(0),
		head.valid ? head.score : SCORE_W'(0)};

endmodule

/* src/tns_cell.sv */
// One cell of the sorted insertion chain: holds one kept entry.
// Depends on tns_pkg.
module tns_cell
	import tns_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic [CNT_W-1:0] cell_pos,
	input  entry_t           prev_entry,
	input  logic             prev_displaced,
	input  entry_t           next_entry,
	output entry_t           entry,
	output logic             displaced
);

	entry_t entry_q;
	logic   trimmed;

	// the new item has the latest index, so it outranks any equal or lower score
	assign displaced = !entry_q.valid || (entry_q.score <= cmd.score);
	assign trimmed   = KEEP_W'(cell_pos) >= cmd.keep;
	assign entry     = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= EMPTY_ENTRY;
		end else if (cmd.clear) begin
			entry_q.valid <= 1'b0;
		end else if (cmd.shift) begin
			entry_q <= next_entry;
		end else if (cmd.ins) begin
			if (prev_displaced) begin
				entry_q.score <= prev_entry.score;
				entry_q.index <= prev_entry.index;
			end else if (displaced) begin
				entry_q.score <= cmd.score;
				entry_q.index <= cmd.index;
			end
			if (trimmed) begin
				entry_q.valid <= 1'b0;
			end else if (prev_displaced) begin
				entry_q.valid <= prev_entry.valid;
			end else if (displaced) begin
				entry_q.valid <= 1'b1;
			end
		end
	end

endmodule

/* src/tns_ctrl.sv */
// Controller of the selector: config registers, arrival position, drain sequencing.
// Depends on tns_pkg.
module tns_ctrl
	import tns_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	input  logic [SCORE_W-1:0] in_score,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	output logic               out_last,
	input  logic               out_ready,
	input  logic               head_valid,
	input  logic               second_valid,
	output cell_cmd_t          cmd
);

	logic [KEEP_W-1:0]  keep_q;
	logic [SCORE_W-1:0] min_q;
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   cnt_q;
	state_t             state_q;
	logic [KEEP_W-1:0]  keep_eff;
	logic               in_acc;
	logic               out_acc;

	always_comb begin
		keep_eff = keep_q;
		if (keep_q == '0) begin
			keep_eff = KEEP_W'(1);
		end else if (keep_q > KEEP_W'(MAX_KEEP)) begin
			keep_eff = KEEP_W'(MAX_KEEP);
		end
	end

	assign in_ready  = (state_q == ST_COLLECT);
	assign out_valid = (state_q == ST_DRAIN);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	// an empty head is the single "nothing qualified" request
	assign out_last = !head_valid || !second_valid
		|| (KEEP_W'(cnt_q) == keep_eff - KEEP_W'(1));

	always_comb begin
		cmd.ins   = in_acc && (pos_q < POS_LIMIT) && (in_score >= min_q);
		cmd.shift = out_acc && !out_last;
		cmd.clear = out_acc && out_last;
		cmd.keep  = keep_eff;
		cmd.score = in_score;
		cmd.index = pos_q[INDEX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
			min_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEEP_COUNT: keep_q <= cfg_data[KEEP_W-1:0];
				REG_MIN_SCORE:  min_q  <= cfg_data[SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (in_acc) begin
						if (in_last) begin
							pos_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_DRAIN;
						end else if (pos_q < POS_LIMIT) begin
							pos_q <= pos_q + POS_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (out_acc) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (out_last) begin
							state_q <= ST_COLLECT;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

endmodule

/* tb/tb_thresholded_top_n_select.sv */
// Testbench for thresholded_top_n_select: directed and random score vectors are checked
// against a built-in top-N tracker, with random stalls on both stream sides.
// Depends on tns_pkg and the RTL of the selector.
module tb;
	import tns_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 170;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [INDEX_W-1:0] index;
		logic               valid;
		logic               last;
	} ranked_t;

	// Keeps its own sorted list of the best scores and the results each closing score owes.
	class topn_tracker;
		logic [KEEP_W-1:0]  keep_reg;
		logic [SCORE_W-1:0] min_reg;
		logic [SCORE_W-1:0] best_score[MAX_KEEP];
		logic [INDEX_W-1:0] best_index[MAX_KEEP];
		bit                 best_valid[MAX_KEEP];
		int                 position;
		ranked_t            ranked_due[$];
		int                 mismatches;
		int                 scores_taken;
		int                 vectors_closed;
		int                 results_checked;

		function new();
			keep_reg = KEEP_RESET;
			min_reg = '0;
			mismatches = 0;
			scores_taken = 0;
			vectors_closed = 0;
			results_checked = 0;
			clear_list();
		endfunction

		function void clear_list();
			for (int i = 0; i < MAX_KEEP; i++) begin
				best_score[i] = '0;
				best_index[i] = '0;
				best_valid[i] = 1'b0;
			end
			position = 0;
		endfunction

		function int active_keep();
			if (keep_reg == 0)
				return 1;
			if (keep_reg > MAX_KEEP)
				return MAX_KEEP;
			return int'(keep_reg);
		endfunction

		function void write_reg(logic idx, logic [7:0] data);
			if (idx == REG_KEEP_COUNT)
				keep_reg = data[KEEP_W-1:0];
			else
				min_reg = data;
		endfunction

		function void note_score(logic [SCORE_W-1:0] sc, logic lst);
			int k;
			int p;
			int n;
			ranked_t r;
			scores_taken++;
			k = active_keep();
			if (position < MAX_CLASSES) begin
				if (sc >= min_reg) begin
					// new entry has the latest index, so it goes ahead of equal scores
					p = 0;
					while (p < k && best_valid[p] && best_score[p] > sc)
						p++;
					if (p < k) begin
						for (int j = MAX_KEEP - 1; j > p; j--) begin
							best_score[j] = best_score[j-1];
							best_index[j] = best_index[j-1];
							best_valid[j] = best_valid[j-1];
						end
						best_score[p] = sc;
						best_index[p] = position[INDEX_W-1:0];
						best_valid[p] = 1'b1;
					end
					for (int j = k; j < MAX_KEEP; j++)
						best_valid[j] = 1'b0;
				end
				position++;
			end
			if (!lst)
				return;
			n = 0;
			for (int i = 0; i < k && best_valid[i]; i++) begin
				r = '0;
				r.score = best_score[i];
				r.index = best_index[i];
				r.valid = 1'b1;
				ranked_due = {ranked_due, r};
				n++;
			end
			if (n == 0) begin
				r = '0;
				r.last = 1'b1;
				ranked_due = {ranked_due, r};
			end else begin
				ranked_due[ranked_due.size()-1].last = 1'b1;
			end
			vectors_closed++;
			clear_list();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
					results_checked, what, got, want);
		endtask

		task check_result(logic [23:0] data, logic user, logic lst);
			ranked_t want;
			results_checked++;
			if (ranked_due.size() == 0) begin
				report("unrequested result", 32'(data), 32'(0));
				return;
			end
			want = ranked_due.pop_front();
			if (data[7:0] !== want.score)
				report("out_score", 32'(data[7:0]), 32'(want.score));
			if (data[19:8] !== want.index)
				report("class_index", 32'(data[19:8]), 32'(want.index));
			if (data[23:20] !== 4'h0)
				report("tdata padding", 32'(data[23:20]), 32'(0));
			if (user !== want.valid)
				report("entry_valid", 32'(user), 32'(want.valid));
			if (lst !== want.last)
				report("last_out", 32'(lst), 32'(want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	bit          send_idle;
	bit          sink_idle;
	int          idle_cycles;
	topn_tracker book = new();

	thresholded_top_n_select i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_score(input logic [7:0] sc, input logic lst);
		int gap;
		gap = send_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sc;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		book.note_score(sc, lst);
	endtask

	// hold off the sender until every owed result is out, then let the block settle
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (book.ranked_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		book.write_reg(idx, data);
	endtask

	// keep count with junk in the unused upper bits; zero and values past 16 included
	function automatic logic [7:0] pick_keep();
		int r;
		int k;
		r = $urandom_range(0, 9);
		case (r)
			0: k = 0;
			1: k = 1;
			2: k = MAX_KEEP;
			3: k = $urandom_range(MAX_KEEP + 1, 31);
			default: k = $urandom_range(1, MAX_KEEP);
		endcase
		return {3'($urandom_range(0, 7)), 5'(k)};
	endfunction

	function automatic logic [7:0] pick_min();
		int r;
		r = $urandom_range(0, 7);
		case (r)
			0: return 8'h00;
			1: return 8'hFF;
			2, 3: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(0, 120));
		endcase
	endfunction

	task automatic random_vector();
		int len;
		int mode;
		int lo;
		int hi;
		int cut;
		logic [7:0] sc;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 18);
		mode = $urandom_range(0, 3);
		lo = $urandom_range(0, 250);
		hi = lo + 5;
		if (mode == 2) begin
			// straddle the minimum so scores land on both sides of it
			lo = (book.min_reg < 3) ? 0 : book.min_reg - 3;
			hi = (book.min_reg > 252) ? 255 : book.min_reg + 3;
		end
		cut = ($urandom_range(0, 9) == 0 && len > 2) ? $urandom_range(1, len - 1) : -1;
		for (int i = 0; i < len; i++) begin
			if (i == cut) begin
				drain_and_settle();
				write_reg(REG_KEEP_COUNT, pick_keep());
			end
			case (mode)
				0: sc = 8'($urandom_range(0, 255));
				3: sc = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				default: sc = 8'($urandom_range(lo, hi));
			endcase
			send_score(sc, i == len - 1);
		end
	endtask

	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			int gap;
			gap = sink_idle ? $urandom_range(0, 15) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			book.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
				idle_cycles++;
			else
				idle_cycles = 0;
		end
		$display("watchdog: no request moved for %0d cycles, %0d results still owed",
			IDLE_LIMIT, book.ranked_due.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int random_start;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		send_idle = 1'b0;
		sink_idle = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes of the score and a tie, later index ranks first
		send_score(8'h00, 1'b0);
		send_score(8'hFF, 1'b0);
		send_score(8'hFF, 1'b0);
		send_score(8'h00, 1'b1);
		drain_and_settle();

		// count 0 acts as 1; highest minimum, then a vector where nothing qualifies
		write_reg(REG_KEEP_COUNT, 8'hE0);
		write_reg(REG_MIN_SCORE, 8'hFF);
		send_score(8'hFE, 1'b0);
		send_score(8'hFF, 1'b1);
		send_score(8'hFE, 1'b1);
		drain_and_settle();

		// count past 16 saturates: a full list of 16 results
		write_reg(REG_KEEP_COUNT, 8'h1F);
		write_reg(REG_MIN_SCORE, 8'h00);
		send_idle = 1'b1;
		sink_idle = 1'b1;
		for (int i = 0; i < MAX_KEEP; i++)
			send_score(8'($urandom_range(0, 255)), i == MAX_KEEP - 1);
		drain_and_settle();

		// count lowered mid-vector with no later insertion: report only the new count
		write_reg(REG_KEEP_COUNT, 8'h10);
		for (int i = 0; i < 4; i++)
			send_score(8'($urandom_range(0, 255)), 1'b0);
		drain_and_settle();
		write_reg(REG_KEEP_COUNT, 8'h02);
		write_reg(REG_MIN_SCORE, 8'hFF);
		send_score(8'h07, 1'b1);
		drain_and_settle();

		random_start = book.scores_taken;
		while (book.scores_taken < random_start + RANDOM_ITEMS) begin
			drain_and_settle();
			write_reg(REG_KEEP_COUNT, pick_keep());
			write_reg(REG_MIN_SCORE, pick_min());
			send_idle = $urandom_range(0, 3) != 0;
			sink_idle = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(2, 5)) random_vector();
		end

		drain_and_settle();
		repeat (20) @(posedge clk);
		$display("run covered %0d scores in %0d vectors, %0d results checked",
			book.scores_taken, book.vectors_closed, book.results_checked);
		if (book.mismatches == 0 && book.ranked_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* thresholded_top_n_select.f */
src/tns_pkg.sv
src/tns_cell.sv
src/tns_ctrl.sv
src/thresholded_top_n_select.sv
tb/tb_thresholded_top_n_select.sv
